// ===== rtl/hcordic_pkg.sv =====
// ============================================================================
// hcordic_pkg: shared constants and elaboration-time tables
// Field widths, default parameter values and the constant functions that
// build the atanh(2^-i) table, the gain-compensation constant and the
// rotation schedule of the hyperbolic CORDIC chain.
// ============================================================================
package hcordic_pkg;

  // Fixed widths of the interface fields.
  localparam int ANGLE_WIDTH = 32;
  localparam int SINH_WIDTH  = 32;
  localparam int COSH_WIDTH  = 31;
  localparam int CFG_WIDTH   = 5;
  localparam int SHIFT_WIDTH = CFG_WIDTH + 1;

  localparam logic [CFG_WIDTH-1:0] COUNT_RESET = CFG_WIDTH'(24);

  // Defaults for the top-level parameters.
  localparam int DATA_WIDTH_DEFAULT     = 32;
  localparam int FRACTION_BITS_DEFAULT  = 29;
  localparam int MAX_ITERATIONS_DEFAULT = 30;

  // Indices that are rotated twice for convergence.
  localparam int REPEAT_A = 4;
  localparam int REPEAT_B = 13;

  // Round to nearest when dropping s low bits.
  function automatic logic [63:0] round_shr(input logic [63:0] v, input int s);
    logic [63:0] half;
    half = (v >> (s - 1)) & 64'd1;
    return (v >> s) + half;
  endfunction

  // Restoring long division, used only while building constants.
  function automatic logic [63:0] long_div(input logic [63:0] n, input logic [63:0] d);
    logic [64:0] r;
    logic [63:0] q;
    r = '0;
    q = '0;
    for (int b = 63; b >= 0; b--) begin
      r = {r[63:0], n[b]};
      if (r >= {1'b0, d}) begin
        r = r - {1'b0, d};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atanh(2^-i) from its power series with 64 fractional bits, rounded at fb.
  function automatic logic [63:0] atanh_fixed(input int i, input int fb);
    logic [63:0] sum;
    logic [63:0] num;
    logic [63:0] d;
    sum = '0;
    for (int k = 0; i * (2 * k + 1) <= 64; k++) begin
      d   = 64'(2 * k + 1);
      num = (64'd1 << (64 - i * (2 * k + 1))) + 64'(k);
      sum = sum + long_div(num, d);
    end
    return round_shr(sum, 64 - fb);
  endfunction

  // Low 64 bits of (a * b) >> s.
  function automatic logic [63:0] mul_shr(input logic [63:0] a, input logic [63:0] b,
                                          input int s);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return 64'(prod >> s);
  endfunction

  // 1/Kh over a full run of max_it indices, repeats included, rounded at fb.
  function automatic logic [63:0] gain_inv_fixed(input int max_it, input int fb);
    logic [63:0] p;
    logic [63:0] y;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] v;
    p = 64'd3 << 62;
    for (int i = 2; i <= max_it; i++) begin
      if (2 * i >= 64) break;
      p = p - (p >> (2 * i));
      if (i == REPEAT_A || i == REPEAT_B) p = p - (p >> (2 * i));
    end
    // Newton iterations for the inverse square root of p.
    y = 64'd1 << 62;
    for (int n = 0; n < 10; n++) begin
      t = mul_shr(y, y, 62);
      u = mul_shr(p, t, 64);
      v = (64'd3 << 62) - u;
      y = mul_shr(y, v, 63);
    end
    return round_shr(y, 62 - fb);
  endfunction

  // Number of rotation cells for a run of max_it indices.
  function automatic int num_cells(input int max_it);
    int n;
    n = max_it;
    if (max_it >= REPEAT_A) n++;
    if (max_it >= REPEAT_B) n++;
    return n;
  endfunction

  // Shift index handled by cell k of the chain.
  function automatic int cell_shift(input int k);
    int c;
    int s;
    c = 0;
    s = 1;
    for (int i = 1; i <= 64; i++) begin
      if (c == k) s = i;
      c++;
      if (i == REPEAT_A || i == REPEAT_B) begin
        if (c == k) s = i;
        c++;
      end
    end
    return s;
  endfunction

endpackage

// ===== rtl/hcordic_cell.sv =====
// ============================================================================
// hcordic_cell: one hyperbolic micro-rotation stage
// Registers x, y and z after one rotation by a fixed shift, or passes them
// through unchanged when the configured count excludes this index.
// ============================================================================
module hcordic_cell
  import hcordic_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
  parameter int SHIFT = 1,
  parameter logic signed [DATA_WIDTH-1:0] ATANH = '0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [CFG_WIDTH-1:0]         iteration_count,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [DATA_WIDTH-1:0] x_in,
  input  logic signed [DATA_WIDTH-1:0] y_in,
  input  logic signed [DATA_WIDTH-1:0] z_in,
  output logic                         dn_valid,
  input  logic                         dn_ready,
  output logic signed [DATA_WIDTH-1:0] x_out,
  output logic signed [DATA_WIDTH-1:0] y_out,
  output logic signed [DATA_WIDTH-1:0] z_out
);

  logic                         rotate;
  logic signed [DATA_WIDTH-1:0] xs, ys;
  logic signed [DATA_WIDTH-1:0] x_next, y_next, z_next;

  assign rotate = SHIFT_WIDTH'(iteration_count) >= SHIFT_WIDTH'(SHIFT);
  assign xs = x_in >>> SHIFT;
  assign ys = y_in >>> SHIFT;

  always_comb begin
    if (!rotate) begin
      x_next = x_in;
      y_next = y_in;
      z_next = z_in;
    end else if (!z_in[DATA_WIDTH-1]) begin
      x_next = x_in + ys;
      y_next = y_in + xs;
      z_next = z_in - ATANH;
    end else begin
      x_next = x_in - ys;
      y_next = y_in - xs;
      z_next = z_in + ATANH;
    end
  end

  // The stage takes a new item when empty or when its item moves on.
  assign up_ready = !dn_valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_out <= x_next;
      y_out <= y_next;
      z_out <= z_next;
    end
  end

endmodule

// ===== rtl/hyperbolic_cordic_sinh_cosh_core.sv =====
// ============================================================================
// hyperbolic_cordic_sinh_cosh_core: sinh and cosh by hyperbolic CORDIC
// Unrolled rotation-mode CORDIC as a chain of registered cells, one cell per
// micro-rotation (indices 4 and 13 have two cells each).
// ============================================================================
//
//   Channel  Handshake               Payload
//   -------  ----------------------  ------------------------------------
//   input    in_valid / in_stall     angle (s32, 29 fractional bits)
//   output   out_valid / out_stall   sinh_value (s32), cosh_value (u31)
//   config   cfg_write               cfg_data (iteration_count, 5 bits)
//
// Throughput is one item per cycle while out_stall is low. Each cell is one
// register; there are MAX_ITERATIONS cells plus the two repeated rotations.
// Every cell is present regardless of iteration_count; cells whose index is
// above the count pass the item through unchanged.
// Reset empties the chain and sets iteration_count to 24.
// A stalled output holds only the items that are blocked behind it: each
// cell loads whenever it is empty, so gaps in the chain close up while the
// output waits, and in_stall rises only when every cell holds an item.
//
module hyperbolic_cordic_sinh_cosh_core
  import hcordic_pkg::*;
#(
  parameter int DATA_WIDTH     = DATA_WIDTH_DEFAULT,
  parameter int FRACTION_BITS  = FRACTION_BITS_DEFAULT,
  parameter int MAX_ITERATIONS = MAX_ITERATIONS_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  // Configuration write port.
  input  logic                         cfg_write,
  input  logic [CFG_WIDTH-1:0]         cfg_data,
  // Input channel.
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_WIDTH-1:0] angle,
  // Output channel.
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [SINH_WIDTH-1:0] sinh_value,
  output logic [COSH_WIDTH-1:0]        cosh_value
);

  localparam int NCELL = num_cells(MAX_ITERATIONS);

  // Starting x: the gain-compensation constant for a full-length run.
  localparam logic signed [DATA_WIDTH-1:0] GAIN_INV =
    DATA_WIDTH'(gain_inv_fixed(MAX_ITERATIONS, FRACTION_BITS));

  logic [CFG_WIDTH-1:0] iteration_count;

  // Links between cells: entry k feeds cell k, entry k+1 is its result.
  logic                         valid_w [NCELL+1];
  logic                         ready_w [NCELL+1];
  logic signed [DATA_WIDTH-1:0] x_w     [NCELL+1];
  logic signed [DATA_WIDTH-1:0] y_w     [NCELL+1];
  logic signed [DATA_WIDTH-1:0] z_w     [NCELL+1];

  // The count must only be written while the chain is empty, so every cell
  // can read it directly; the block itself does not enforce this.
  always_ff @(posedge clk) begin
    if (rst) begin
      iteration_count <= COUNT_RESET;
    end else if (cfg_write) begin
      iteration_count <= cfg_data;
    end
  end

  // Head of the chain: x at 1/Kh, y at zero, z at the sign-extended angle.
  assign valid_w[0] = in_valid;
  assign in_stall   = !ready_w[0];
  assign x_w[0]     = GAIN_INV;
  assign y_w[0]     = '0;
  assign z_w[0]     = DATA_WIDTH'(angle);

  for (genvar k = 0; k < NCELL; k++) begin : g_cell
    localparam int SHIFT = cell_shift(k);
    localparam logic signed [DATA_WIDTH-1:0] ATANH =
      DATA_WIDTH'(atanh_fixed(SHIFT, FRACTION_BITS));

    hcordic_cell #(
      .DATA_WIDTH (DATA_WIDTH),
      .SHIFT      (SHIFT),
      .ATANH      (ATANH)
    ) u_cell (
      .clk             (clk),
      .rst             (rst),
      .iteration_count (iteration_count),
      .up_valid        (valid_w[k]),
      .up_ready        (ready_w[k]),
      .x_in            (x_w[k]),
      .y_in            (y_w[k]),
      .z_in            (z_w[k]),
      .dn_valid        (valid_w[k+1]),
      .dn_ready        (ready_w[k+1]),
      .x_out           (x_w[k+1]),
      .y_out           (y_w[k+1]),
      .z_out           (z_w[k+1])
    );
  end

  // The last cell's registers are the output register. The residual angle
  // left in its z register is not part of the result.
  assign ready_w[NCELL] = !out_stall;
  assign out_valid      = valid_w[NCELL];
  assign sinh_value     = SINH_WIDTH'(y_w[NCELL]);
  assign cosh_value     = COSH_WIDTH'(x_w[NCELL]);

endmodule
